// ===== hw/rtl/apfm_pkg.sv =====
// Shared types, widths, constants and trig table for the affine pixel forward map.
`timescale 1ns / 1ps

package apfm_pkg;

    // Field widths
    localparam int W_COORD    = 8;
    localparam int W_COLOR    = 8;
    localparam int W_ANGLE    = 9;
    localparam int W_SCALE    = 7;
    localparam int W_SHEAR    = 8;
    localparam int W_SHIFT    = 10;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 10;

    // Image size defaults
    localparam int IMG_WIDTH_DEF  = 256;
    localparam int IMG_HEIGHT_DEF = 256;

    // Datapath widths: centered coordinate, coefficient, product, sum
    localparam int W_CTR  = 11;
    localparam int W_COEF = 31;
    localparam int W_PROD = W_COEF + W_CTR;
    localparam int W_SUM  = W_PROD + 1;
    localparam int W_DIVN = 31;
    localparam int W_RCP  = 32;
    localparam int W_RPRD = W_DIVN + W_RCP;
    localparam int W_POS  = 27;
    localparam int W_TRIG = 16;

    // Floor divide by 64000 = shift by 9, then divide by 125 through a reciprocal
    localparam int                       DIV_SHIFT = 9;
    localparam logic signed [W_SUM-1:0]  DIV_BIAS  = 43'sd1048576000;  // 125 * 2^23
    localparam logic [W_RCP-1:0]         RCP_125   = 32'd2199023256;   // ceil(2^38 / 125)
    localparam int                       RCP_SHIFT = 38;
    localparam logic signed [W_POS-1:0]  Q_BIAS    = 27'sd8388608;     // 2^23

    // Config register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_ANGLE   = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_SCALE_X = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_SCALE_Y = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_SHEAR_X = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_SHEAR_Y = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_SHIFT_X = 3'd5;
    localparam logic [W_CFG_IDX-1:0] CFG_SHIFT_Y = 3'd6;

    // Config reset values
    localparam logic [W_ANGLE-1:0] RST_ANGLE = 9'd0;
    localparam logic [W_SCALE-1:0] RST_SCALE = 7'd50;
    localparam logic [W_SHEAR-1:0] RST_SHEAR = 8'd0;
    localparam logic [W_SHIFT-1:0] RST_SHIFT = 10'd0;

    // Cycles of input hold-off while the coefficient registers refill
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    typedef logic signed [W_TRIG-1:0] t_trig;
    typedef logic [90:0][14:0] t_sin_tbl;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] Q30_HALF = 64'd536870912;

    // Advance a Taylor term by x^2 in Q30
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // Quarter-wave sine of d degrees in Q14, series to the x^15 term
    function automatic logic [14:0] quarter_sine(input logic [6:0] d);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rnd;
        x    = (64'(d) * PI_Q30) / 64'd180;
        term = x;
        acc  = $signed(x);
        term = sq_step(term, x) / 64'd6;
        acc  = acc - $signed(term);
        term = sq_step(term, x) / 64'd20;
        acc  = acc + $signed(term);
        term = sq_step(term, x) / 64'd42;
        acc  = acc - $signed(term);
        term = sq_step(term, x) / 64'd72;
        acc  = acc + $signed(term);
        term = sq_step(term, x) / 64'd110;
        acc  = acc - $signed(term);
        term = sq_step(term, x) / 64'd156;
        acc  = acc + $signed(term);
        term = sq_step(term, x) / 64'd210;
        acc  = acc - $signed(term);
        if (acc < 0) begin
            acc = 64'sd0;
        end
        rnd = ($unsigned(acc) * 64'd16384 + Q30_HALF) >> 30;
        return rnd[14:0];
    endfunction

    function automatic t_sin_tbl build_sin_tbl();
        t_sin_tbl t;
        for (int d = 0; d <= 90; d++) begin
            t[d] = quarter_sine(7'(d));
        end
        return t;
    endfunction

    localparam t_sin_tbl SIN_TBL = build_sin_tbl();

    // Sine of a whole degree 0..359 in Q2.14, folded onto the quarter table
    function automatic t_trig sin_deg(input logic [W_ANGLE-1:0] d);
        logic [W_ANGLE-1:0] r;
        logic               neg;
        t_trig              mag;
        neg = 1'b0;
        r   = d;
        if (d <= 9'd90) begin
            r = d;
        end else if (d <= 9'd180) begin
            r = 9'd180 - d;
        end else if (d <= 9'd270) begin
            r   = d - 9'd180;
            neg = 1'b1;
        end else begin
            r   = 9'd360 - d;
            neg = 1'b1;
        end
        mag = t_trig'({1'b0, SIN_TBL[r[6:0]]});
        return neg ? -mag : mag;
    endfunction

endpackage

// ===== hw/rtl/affine_pixel_forward_map.sv =====
// Affine forward mapping of streamed source pixels to destination pixels.
// A result passes the stage 1 to 4 registers and the output register before it is shown.
// Throughput: one pixel per cycle through a 5-register pipeline, when not stalled by the output
// or a config write; pixels outside are dropped. After a config write, input ready stays low
// while the 3-stage coefficient pipeline (sine lookup, products, coefficients) refills.
// Reset: synchronous active low; clears valid bits and loads config defaults.
`timescale 1ns / 1ps

module affine_pixel_forward_map
    import apfm_pkg::*;
#(
    parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [W_CFG_IDX-1:0]  i_cfg_index,
    input  logic [W_CFG_DATA-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [W_COORD-1:0]    i_src_x,
    input  logic [W_COORD-1:0]    i_src_y,
    input  logic [W_COLOR-1:0]    i_blue_in,
    input  logic [W_COLOR-1:0]    i_green_in,
    input  logic [W_COLOR-1:0]    i_red_in,
    // pixel output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [W_COORD-1:0]    o_dest_x,
    output logic [W_COORD-1:0]    o_dest_y,
    output logic [W_COLOR-1:0]    o_blue_out,
    output logic [W_COLOR-1:0]    o_green_out,
    output logic [W_COLOR-1:0]    o_red_out
);

    localparam logic signed [W_CTR-1:0] CX    = W_CTR'(IMG_WIDTH / 2);
    localparam logic signed [W_CTR-1:0] CY    = W_CTR'(IMG_HEIGHT / 2);
    localparam logic signed [W_POS-1:0] X_LIM = W_POS'(IMG_WIDTH * 256);
    localparam logic signed [W_POS-1:0] Y_LIM = W_POS'(IMG_HEIGHT * 256);

    // Config registers
    logic [W_ANGLE-1:0] r_angle;
    logic [W_SCALE-1:0] r_scale_x;
    logic [W_SCALE-1:0] r_scale_y;
    logic [W_SHEAR-1:0] r_shear_x;
    logic [W_SHEAR-1:0] r_shear_y;
    logic [W_SHIFT-1:0] r_shift_x;
    logic [W_SHIFT-1:0] r_shift_y;
    logic [1:0]         r_settle;

    // Coefficient pipeline
    logic [W_ANGLE-1:0]      w_ang;
    logic [W_ANGLE:0]        w_cang_sum;
    logic [W_ANGLE-1:0]      w_cang;
    logic signed [W_SCALE:0] w_sx;
    logic signed [W_SCALE:0] w_sy;
    t_trig                   r_sin;
    t_trig                   r_cos;
    logic signed [23:0]      r_csx;
    logic signed [23:0]      r_ssy;
    logic signed [24:0]      r_hxs;
    logic signed [24:0]      r_hyc;
    logic signed [W_COEF-1:0] r_coef_a;
    logic signed [W_COEF-1:0] r_coef_b;
    logic signed [W_COEF-1:0] r_coef_c;
    logic signed [W_COEF-1:0] r_coef_d;

    // Pixel pipeline
    logic                     r_v1, r_v2, r_v3, r_v4;
    logic signed [W_CTR-1:0]  r_x1, r_y1;
    logic signed [W_PROD-1:0] r_pax, r_pby, r_pcx, r_pdy;
    logic [W_DIVN-1:0]        r_mx, r_my;
    logic [W_RPRD-1:0]        r_px, r_py;
    logic [W_COLOR-1:0]       r_b1, r_g1, r_r1;
    logic [W_COLOR-1:0]       r_b2, r_g2, r_r2;
    logic [W_COLOR-1:0]       r_b3, r_g3, r_r3;
    logic [W_COLOR-1:0]       r_b4, r_g4, r_r4;
    logic                     r_out_valid;
    logic [W_COORD-1:0]       r_dest_x, r_dest_y;
    logic [W_COLOR-1:0]       r_blue, r_green, r_red;

    logic w_rdy_out, w_rdy4, w_rdy3, w_rdy2, w_rdy1, w_in_acc;

    logic signed [W_SUM-1:0]  n_nx, n_ny;
    logic signed [W_SUM-1:0]  n_mx, n_my;
    logic [W_POS-3:0]         w_qx, w_qy;
    logic signed [W_CTR-1:0]  w_offx, w_offy;
    logic signed [W_POS-1:0]  n_xq, n_yq;
    logic                     w_inside;

    // Config writes; hold off pixels while coefficients refill
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle   <= RST_ANGLE;
            r_scale_x <= RST_SCALE;
            r_scale_y <= RST_SCALE;
            r_shear_x <= RST_SHEAR;
            r_shear_y <= RST_SHEAR;
            r_shift_x <= RST_SHIFT;
            r_shift_y <= RST_SHIFT;
            r_settle  <= CFG_SETTLE;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_settle <= CFG_SETTLE;
                unique case (i_cfg_index)
                    CFG_ANGLE:   r_angle   <= i_cfg_data[W_ANGLE-1:0];
                    CFG_SCALE_X: r_scale_x <= i_cfg_data[W_SCALE-1:0];
                    CFG_SCALE_Y: r_scale_y <= i_cfg_data[W_SCALE-1:0];
                    CFG_SHEAR_X: r_shear_x <= i_cfg_data[W_SHEAR-1:0];
                    CFG_SHEAR_Y: r_shear_y <= i_cfg_data[W_SHEAR-1:0];
                    CFG_SHIFT_X: r_shift_x <= i_cfg_data[W_SHIFT-1:0];
                    CFG_SHIFT_Y: r_shift_y <= i_cfg_data[W_SHIFT-1:0];
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // Reduce angle modulo 360; cosine is the sine 90 degrees on
    always_comb begin
        w_ang      = (r_angle >= 9'd360) ? (r_angle - 9'd360) : r_angle;
        w_cang_sum = {1'b0, w_ang} + 10'd90;
        w_cang     = (w_cang_sum >= 10'd360) ? W_ANGLE'(w_cang_sum - 10'd360)
                                             : w_cang_sum[W_ANGLE-1:0];
    end

    assign w_sx = $signed({1'b0, r_scale_x});
    assign w_sy = $signed({1'b0, r_scale_y});

    // Coefficients: A = 20*c*sx, B = (c*hx - 20*s)*sx, C = 20*s*sy, D = c*(hy+20)*sy
    always_ff @(posedge i_clk) begin
        r_sin    <= sin_deg(w_ang);
        r_cos    <= sin_deg(w_cang);
        r_csx    <= 24'(r_cos) * 24'(w_sx);
        r_ssy    <= 24'(r_sin) * 24'(w_sy);
        r_hxs    <= 25'(r_cos) * 25'($signed(r_shear_x)) - 25'(r_sin) * 25'sd20;
        r_hyc    <= 25'(r_cos) * (25'($signed(r_shear_y)) + 25'sd20);
        r_coef_a <= W_COEF'(r_csx) * 31'sd20;
        r_coef_b <= W_COEF'(r_hxs) * W_COEF'(w_sx);
        r_coef_c <= W_COEF'(r_ssy) * 31'sd20;
        r_coef_d <= W_COEF'(r_hyc) * W_COEF'(w_sy);
    end

    // Stall chain: each stage advances when the next one frees up
    assign w_rdy_out  = !r_out_valid || i_out_ready;
    assign w_rdy4     = !r_v4 || w_rdy_out;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1 && (r_settle == 2'd0);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1)    r_v1        <= w_in_acc;
            if (w_rdy2)    r_v2        <= r_v1;
            if (w_rdy3)    r_v3        <= r_v2;
            if (w_rdy4)    r_v4        <= r_v3;
            if (w_rdy_out) r_out_valid <= r_v4 && w_inside;
        end
    end

    // Stage 1: capture beat and center coordinates
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_x1 <= $signed({3'b000, i_src_x}) - CX;
            r_y1 <= $signed({3'b000, i_src_y}) - CY;
            r_b1 <= i_blue_in;
            r_g1 <= i_green_in;
            r_r1 <= i_red_in;
        end
    end

    // Stage 2: four coefficient products
    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_pax <= W_PROD'(r_coef_a) * W_PROD'(r_x1);
            r_pby <= W_PROD'(r_coef_b) * W_PROD'(r_y1);
            r_pcx <= W_PROD'(r_coef_c) * W_PROD'(r_x1);
            r_pdy <= W_PROD'(r_coef_d) * W_PROD'(r_y1);
            r_b2  <= r_b1;
            r_g2  <= r_g1;
            r_r2  <= r_r1;
        end
    end

    // Stage 3: sum, floor-shift by 512, bias to a non-negative dividend
    always_comb begin
        n_nx = W_SUM'(r_pax) + W_SUM'(r_pby);
        n_ny = W_SUM'(r_pcx) + W_SUM'(r_pdy);
        n_mx = (n_nx >>> DIV_SHIFT) + DIV_BIAS;
        n_my = (n_ny >>> DIV_SHIFT) + DIV_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_mx <= n_mx[W_DIVN-1:0];
            r_my <= n_my[W_DIVN-1:0];
            r_b3 <= r_b2;
            r_g3 <= r_g2;
            r_r3 <= r_r2;
        end
    end

    // Stage 4: divide by 125 through the reciprocal
    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_px <= W_RPRD'(r_mx) * W_RPRD'(RCP_125);
            r_py <= W_RPRD'(r_my) * W_RPRD'(RCP_125);
            r_b4 <= r_b3;
            r_g4 <= r_g3;
            r_r4 <= r_r3;
        end
    end

    // Output stage: drop the bias, translate, recenter, test inside
    always_comb begin
        w_qx     = r_px[W_RPRD-1:RCP_SHIFT];
        w_qy     = r_py[W_RPRD-1:RCP_SHIFT];
        w_offx   = W_CTR'(signed'(r_shift_x)) + CX;
        w_offy   = W_CTR'(signed'(r_shift_y)) + CY;
        n_xq     = $signed({2'b00, w_qx}) - Q_BIAS + W_POS'($signed({w_offx, 8'h00}));
        n_yq     = $signed({2'b00, w_qy}) - Q_BIAS + W_POS'($signed({w_offy, 8'h00}));
        w_inside = (n_xq > W_POS'(0)) && (n_xq < X_LIM) &&
                   (n_yq > W_POS'(0)) && (n_yq < Y_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_dest_x <= n_xq[15:8];
            r_dest_y <= n_yq[15:8];
            r_blue   <= r_b4;
            r_green  <= r_g4;
            r_red    <= r_r4;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dest_x    = r_dest_x;
    assign o_dest_y    = r_dest_y;
    assign o_blue_out  = r_blue;
    assign o_green_out = r_green;
    assign o_red_out   = r_red;

endmodule
